@@ hdl/text_glyph_framebuffer_renderer_macros.svh @@
// Assertion macros for the text glyph framebuffer renderer.
// Included by the top level; compiled away when SYNTHESIS is defined.
`ifndef TEXT_GLYPH_FRAMEBUFFER_RENDERER_MACROS_SVH
`define TEXT_GLYPH_FRAMEBUFFER_RENDERER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TGFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgfr assertion failed (same cycle)");
// next-cycle implication
`define TGFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgfr assertion failed (next cycle)");
`else
`define TGFR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TGFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/tgfr_pkg.sv @@
// Shared constants, types and the 5x7 font for the glyph renderer.
// No dependencies; used by tgfr_fbram and the top level.
package tgfr_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 64;
    localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
    localparam int FB_BYTES     = PANEL_WIDTH * PAGE_COUNT;
    localparam int FB_AW        = $clog2(FB_BYTES);
    localparam int GLYPH_COLS   = 5;
    localparam int CELL_COLS    = 6;
    localparam int GLYPH_ROWS   = 7;
    localparam int LINE_STEP    = 8;

    localparam logic [2:0] CMD_DRAW    = 3'd0;
    localparam logic [2:0] CMD_NEWLINE = 3'd1;
    localparam logic [2:0] CMD_CLEAR   = 3'd2;
    localparam logic [2:0] CMD_SETPOS  = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    // column 0 of the glyph at index 0
    typedef logic [0:GLYPH_COLS-1][7:0] t_glyph;

    typedef struct packed {
        logic             we;
        logic [FB_AW-1:0] addr;
        logic [7:0]       data;
    } t_wr_req;

    // Folds lowercase, maps unknown codes (NUL too) to '?'.
    function automatic t_glyph font_lookup(input logic [7:0] code);
        logic [7:0] up;
        t_glyph     g;
        up = (code >= 8'h61 && code <= 8'h7a) ? code - 8'd32 : code;
        case (up)
            8'h20: g = 40'h00_00_00_00_00;
            8'h30: g = 40'h3e_51_49_45_3e;
            8'h31: g = 40'h00_42_7f_40_00;
            8'h32: g = 40'h42_61_51_49_46;
            8'h33: g = 40'h21_41_45_4b_31;
            8'h34: g = 40'h18_14_12_7f_10;
            8'h35: g = 40'h27_45_45_45_39;
            8'h36: g = 40'h3c_4a_49_49_30;
            8'h37: g = 40'h01_71_09_05_03;
            8'h38: g = 40'h36_49_49_49_36;
            8'h39: g = 40'h06_49_49_29_1e;
            8'h41: g = 40'h7e_11_11_11_7e;
            8'h42: g = 40'h7f_49_49_49_36;
            8'h43: g = 40'h3e_41_41_41_22;
            8'h44: g = 40'h7f_41_41_22_1c;
            8'h45: g = 40'h7f_49_49_49_41;
            8'h46: g = 40'h7f_09_09_09_01;
            8'h47: g = 40'h3e_41_49_49_7a;
            8'h48: g = 40'h7f_08_08_08_7f;
            8'h49: g = 40'h00_41_7f_41_00;
            8'h4a: g = 40'h20_40_41_3f_01;
            8'h4b: g = 40'h7f_08_14_22_41;
            8'h4c: g = 40'h7f_40_40_40_40;
            8'h4d: g = 40'h7f_02_0c_02_7f;
            8'h4e: g = 40'h7f_04_08_10_7f;
            8'h4f: g = 40'h3e_41_41_41_3e;
            8'h50: g = 40'h7f_09_09_09_06;
            8'h51: g = 40'h3e_41_51_21_5e;
            8'h52: g = 40'h7f_09_19_29_46;
            8'h53: g = 40'h46_49_49_49_31;
            8'h54: g = 40'h01_01_7f_01_01;
            8'h55: g = 40'h3f_40_40_40_3f;
            8'h56: g = 40'h1f_20_40_20_1f;
            8'h57: g = 40'h3f_40_38_40_3f;
            8'h58: g = 40'h63_14_08_14_63;
            8'h59: g = 40'h07_08_70_08_07;
            8'h5a: g = 40'h61_51_49_45_43;
            8'h2e: g = 40'h00_60_60_00_00;
            8'h2d: g = 40'h08_08_08_08_08;
            8'h5f: g = 40'h40_40_40_40_40;
            8'h3a: g = 40'h00_36_36_00_00;
            8'h2f: g = 40'h20_10_08_04_02;
            8'h21: g = 40'h00_00_5f_00_00;
            default: g = 40'h02_01_51_09_06;
        endcase
        return g;
    endfunction

endpackage

@@ hdl/tgfr_fbram.sv @@
// Framebuffer byte store: one write port, one read port with registered data.
// Depends on tgfr_pkg.
module tgfr_fbram (
    input  logic                       i_clk,
    input  tgfr_pkg::t_wr_req          i_wr,
    input  logic                       i_rd_en,
    input  logic [tgfr_pkg::FB_AW-1:0] i_rd_addr,
    output logic [7:0]                 o_rd_data
);
    import tgfr_pkg::*;

    logic [7:0] mem [FB_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/text_glyph_framebuffer_renderer.sv @@
// Text renderer over a page-organized monochrome framebuffer.
// Command stream on s_*, one result per command on m_*.
// Draw: lowercase folds to upper case, unknown codes draw '?', code 10 is a newline;
//   a glyph cell is 6 columns by 7 rows, read-modify-written into up to 12 bytes.
// Newline, set position (rejected with status 1 when out of range), read byte.
// Newline, set position, read and unused codes go from idle straight to the emit
//   state, which loads the result; a drawn glyph runs 12 pipelined RMW steps
//   through the framebuffer RAM and a drain step before the emit state; clear
//   sweeps all 1024 bytes one per cycle before the emit state.
// One command is in work at a time; the next is taken the cycle after the result
//   is loaded.
// After reset the framebuffer is swept to zero, with s_tready low throughout the
//   sweep. The cursor resets to column 0, row 0.
// The result sits in an output register; a stalled m_tready holds it and the
//   block still takes the next command, which waits for the register to free.
`include "text_glyph_framebuffer_renderer_macros.svh"

module text_glyph_framebuffer_renderer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0], char_code[10:3], pos_x[18:11], pos_y[26:19], address[36:27], zero pad
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[0], read_data[8:1], cursor_col[16:9], cursor_row[22:17], zero pad
    output logic [23:0] m_tdata
);
    import tgfr_pkg::*;

    localparam int GLYPH_STEPS = CELL_COLS * 2;
    localparam int STEP_W      = $clog2(GLYPH_STEPS + 1);

    typedef enum logic [1:0] {S_SWEEP, S_IDLE, S_GLYPH, S_EMIT} t_state;

    t_state           r_state;
    logic [FB_AW-1:0] r_sweep;
    logic             r_clr_emit;
    logic [7:0]       r_col;
    logic [5:0]       r_row;
    logic             r_status;
    logic             r_is_read;
    logic [7:0]       r_x0;
    logic [5:0]       r_y0;
    t_glyph           r_glyph;
    logic [STEP_W-1:0] r_step;
    logic             r_p_valid;
    logic [FB_AW-1:0] r_p_addr;
    logic [7:0]       r_p_bits;
    logic [7:0]       r_p_mask;
    logic             r_m_valid;
    logic [23:0]      r_m_data;

    logic       w_accept;
    logic [2:0] w_cmd;
    logic [7:0] w_code;
    logic [7:0] w_px;
    logic [7:0] w_py;
    logic [9:0] w_addr;
    logic [5:0] w_nl_row;
    logic       w_wrap;
    logic [7:0] w_x0;
    logic [5:0] w_y0;
    logic       w_pos_bad;
    logic       w_clr_go;
    logic       w_at_home;

    logic [2:0]       st_col;
    logic             st_pg;
    logic [7:0]       st_colbits;
    logic [15:0]      st_sh;
    logic [15:0]      st_mk;
    logic [7:0]       st_bits;
    logic [7:0]       st_mask;
    logic [8:0]       st_x;
    logic [3:0]       st_page;
    logic             st_ok;
    logic [FB_AW-1:0] st_addr;
    logic             st_issue;

    t_wr_req          w_wr;
    logic             w_rd_en;
    logic [FB_AW-1:0] w_rd_addr;
    logic [7:0]       w_rd_data;

    assign s_tready = (r_state == S_IDLE);
    assign w_accept = s_tvalid && s_tready;
    assign w_cmd    = s_tdata[2:0];
    assign w_code   = s_tdata[10:3];
    assign w_px     = s_tdata[18:11];
    assign w_py     = s_tdata[26:19];
    assign w_addr   = s_tdata[36:27];

    assign w_clr_go  = w_accept && (w_cmd == CMD_CLEAR);
    assign w_at_home = (r_col == 8'd0) && (r_row == 6'd0);

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    // cursor arithmetic for the command at the input
    always_comb begin
        w_nl_row  = (r_row > 6'(PANEL_HEIGHT - 9)) ? 6'd0 : r_row + 6'(LINE_STEP);
        w_wrap    = (9'(r_col) + 9'(CELL_COLS)) > 9'(PANEL_WIDTH);
        w_x0      = w_wrap ? 8'd0 : r_col;
        w_y0      = w_wrap ? w_nl_row : r_row;
        w_pos_bad = (w_px > 8'(PANEL_WIDTH - CELL_COLS)) ||
                    (w_py > 8'(PANEL_HEIGHT - GLYPH_ROWS));
    end

    // glyph step decode: step = column * 2 + page half
    always_comb begin
        st_col     = r_step[3:1];
        st_pg      = r_step[0];
        st_colbits = (st_col < 3'(GLYPH_COLS)) ? r_glyph[st_col] : 8'd0;
        st_sh      = {9'd0, st_colbits[6:0]} << r_y0[2:0];
        st_mk      = 16'h007f << r_y0[2:0];
        st_bits    = st_pg ? st_sh[15:8] : st_sh[7:0];
        st_mask    = st_pg ? st_mk[15:8] : st_mk[7:0];
        st_x       = 9'(r_x0) + 9'(st_col);
        st_page    = 4'(r_y0[5:3]) + 4'(st_pg);
        st_ok      = (st_x < 9'(PANEL_WIDTH)) && (st_page < 4'(PAGE_COUNT)) &&
                     (st_mask != 8'd0);
        st_addr    = FB_AW'(32'(st_page) * PANEL_WIDTH + 32'(st_x));
        st_issue   = (r_state == S_GLYPH) && (r_step < STEP_W'(GLYPH_STEPS));
    end

    // RAM ports: sweep writes zero, glyph writes back the byte read in the cycle before
    always_comb begin
        w_wr      = '0;
        w_rd_en   = 1'b0;
        w_rd_addr = w_addr;
        case (r_state)
            S_SWEEP: begin
                w_wr.we   = 1'b1;
                w_wr.addr = r_sweep;
                w_wr.data = 8'd0;
            end
            S_IDLE: begin
                w_rd_en = w_accept && (w_cmd == CMD_READ);
            end
            S_GLYPH: begin
                w_rd_en   = st_issue;
                w_rd_addr = st_addr;
                w_wr.we   = r_p_valid;
                w_wr.addr = r_p_addr;
                w_wr.data = (w_rd_data & ~r_p_mask) | (r_p_bits & r_p_mask);
            end
            default: begin
            end
        endcase
    end

    tgfr_fbram u_fbram (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_SWEEP;
            r_sweep    <= '0;
            r_clr_emit <= 1'b0;
            r_col      <= 8'd0;
            r_row      <= 6'd0;
            r_step     <= '0;
            r_p_valid  <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            // in S_EMIT the load below covers the drain
            if (r_m_valid && m_tready && (r_state != S_EMIT)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_SWEEP: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == FB_AW'(FB_BYTES - 1)) begin
                        r_clr_emit <= 1'b0;
                        r_state    <= r_clr_emit ? S_EMIT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_status  <= 1'b0;
                        r_is_read <= 1'b0;
                        r_state   <= S_EMIT;
                        case (w_cmd)
                            CMD_DRAW: begin
                                if (w_code == CHAR_NEWLINE) begin
                                    r_col <= 8'd0;
                                    r_row <= w_nl_row;
                                end else begin
                                    r_x0      <= w_x0;
                                    r_y0      <= w_y0;
                                    r_glyph   <= font_lookup(w_code);
                                    r_col     <= w_x0 + 8'(CELL_COLS);
                                    r_row     <= w_y0;
                                    r_step    <= '0;
                                    r_p_valid <= 1'b0;
                                    r_state   <= S_GLYPH;
                                end
                            end
                            CMD_NEWLINE: begin
                                r_col <= 8'd0;
                                r_row <= w_nl_row;
                            end
                            CMD_CLEAR: begin
                                r_col      <= 8'd0;
                                r_row      <= 6'd0;
                                r_sweep    <= '0;
                                r_clr_emit <= 1'b1;
                                r_state    <= S_SWEEP;
                            end
                            CMD_SETPOS: begin
                                if (w_pos_bad) begin
                                    r_status <= 1'b1;
                                end else begin
                                    r_col <= w_px;
                                    r_row <= w_py[5:0];
                                end
                            end
                            CMD_READ: begin
                                r_is_read <= 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_GLYPH: begin
                    r_p_valid <= st_issue && st_ok;
                    r_p_addr  <= st_addr;
                    r_p_bits  <= st_bits;
                    r_p_mask  <= st_mask;
                    r_step    <= r_step + 1'b1;
                    if (r_step == STEP_W'(GLYPH_STEPS)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_m_valid || m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {1'b0, r_row, r_col,
                                      (r_is_read ? w_rd_data : 8'd0), r_status};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `TGFR_ASSERT_IMPL(a_col_range, i_clk, i_rst_n, 1'b1, 9'(r_col) <= 9'(PANEL_WIDTH))
    `TGFR_ASSERT_IMPL(a_pipe_empty, i_clk, i_rst_n, r_state == S_GLYPH && r_step == '0, !r_p_valid)
    `TGFR_ASSERT_NEXT(a_clear_home, i_clk, i_rst_n, w_clr_go, r_state == S_SWEEP && w_at_home)
    `TGFR_ASSERT_IMPL(a_reject_nodata, i_clk, i_rst_n, m_tvalid && m_tdata[0], m_tdata[8:1] == 8'd0)

endmodule

@@ tb/sv/tb.sv @@
// Testbench for text_glyph_framebuffer_renderer: random command streams with random stalls.
// A scoreboard class holds its own framebuffer and cursor to predict each result.
// Depends on tgfr_pkg for panel sizes and command codes.
module tb;
    import tgfr_pkg::*;

    class glyph_scoreboard;
        typedef struct packed {
            logic       status;
            logic [7:0] data;
            logic [7:0] col;
            logic [5:0] row;
        } t_result;

        logic [7:0]  frame [FB_BYTES];
        logic [7:0]  col_now;
        logic [5:0]  row_now;
        string       font_chars;
        logic [39:0] font_cols [44];   // column 0 in bits [39:32]
        t_result     awaited_results [$];
        int          failures;

        function new();
            font_chars = " 0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ.-_:/?!";
            font_cols = '{
                40'h00_00_00_00_00, 40'h3e_51_49_45_3e, 40'h00_42_7f_40_00,
                40'h42_61_51_49_46, 40'h21_41_45_4b_31, 40'h18_14_12_7f_10,
                40'h27_45_45_45_39, 40'h3c_4a_49_49_30, 40'h01_71_09_05_03,
                40'h36_49_49_49_36, 40'h06_49_49_29_1e, 40'h7e_11_11_11_7e,
                40'h7f_49_49_49_36, 40'h3e_41_41_41_22, 40'h7f_41_41_22_1c,
                40'h7f_49_49_49_41, 40'h7f_09_09_09_01, 40'h3e_41_49_49_7a,
                40'h7f_08_08_08_7f, 40'h00_41_7f_41_00, 40'h20_40_41_3f_01,
                40'h7f_08_14_22_41, 40'h7f_40_40_40_40, 40'h7f_02_0c_02_7f,
                40'h7f_04_08_10_7f, 40'h3e_41_41_41_3e, 40'h7f_09_09_09_06,
                40'h3e_41_51_21_5e, 40'h7f_09_19_29_46, 40'h46_49_49_49_31,
                40'h01_01_7f_01_01, 40'h3f_40_40_40_3f, 40'h1f_20_40_20_1f,
                40'h3f_40_38_40_3f, 40'h63_14_08_14_63, 40'h07_08_70_08_07,
                40'h61_51_49_45_43, 40'h00_60_60_00_00, 40'h08_08_08_08_08,
                40'h40_40_40_40_40, 40'h00_36_36_00_00, 40'h20_10_08_04_02,
                40'h02_01_51_09_06, 40'h00_00_5f_00_00
            };
            failures = 0;
            wipe_screen();
        endfunction

        function void wipe_screen();
            foreach (frame[i]) frame[i] = 8'h00;
            col_now = 8'd0;
            row_now = 6'd0;
        endfunction

        function void line_feed();
            col_now = 8'd0;
            if (int'(row_now) > PANEL_HEIGHT - 9)
                row_now = 6'd0;
            else
                row_now = row_now + 6'(LINE_STEP);
        endfunction

        // lowercase folds up; anything missing from the font (NUL too) maps to '?'
        function int glyph_index(logic [7:0] code);
            logic [7:0] up;
            up = (code >= 8'h61 && code <= 8'h7a) ? code - 8'd32 : code;
            for (int i = 0; i < 44; i++)
                if (font_chars[i] == up) return i;
            return 42;
        endfunction

        function void render_glyph(logic [7:0] code);
            logic [7:0] bits;
            int g, x, y, off;
            if (code == CHAR_NEWLINE) begin
                line_feed();
                return;
            end
            if (int'(col_now) + CELL_COLS > PANEL_WIDTH) line_feed();
            g = glyph_index(code);
            for (int c = 0; c < CELL_COLS; c++) begin
                bits = (c < GLYPH_COLS) ? font_cols[g][39 - 8 * c -: 8] : 8'h00;
                for (int r = 0; r < GLYPH_ROWS; r++) begin
                    x = int'(col_now) + c;
                    y = int'(row_now) + r;
                    if (x >= PANEL_WIDTH || y >= PANEL_HEIGHT) continue;
                    off = (y / 8) * PANEL_WIDTH + x;
                    frame[off][y % 8] = bits[r];
                end
            end
            col_now = col_now + 8'(CELL_COLS);
        endfunction

        function void note_command(logic [2:0] cmd, logic [7:0] code, logic [7:0] px,
                                   logic [7:0] py, logic [9:0] addr);
            t_result res;
            res = '0;
            case (cmd)
                CMD_DRAW:    render_glyph(code);
                CMD_NEWLINE: line_feed();
                CMD_CLEAR:   wipe_screen();
                CMD_SETPOS: begin
                    if (int'(px) > PANEL_WIDTH - CELL_COLS || int'(py) > PANEL_HEIGHT - GLYPH_ROWS)
                        res.status = 1'b1;
                    else begin
                        col_now = px;
                        row_now = py[5:0];
                    end
                end
                CMD_READ: begin
                    if (int'(addr) < FB_BYTES) res.data = frame[addr];
                end
                default: ;
            endcase
            res.col = col_now;
            res.row = row_now;
            awaited_results.push_back(res);
        endfunction

        function void check_result(logic [23:0] word);
            t_result want;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, word);
                failures++;
                return;
            end
            want = awaited_results.pop_front();
            if (word[0] !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, word[0]);
                failures++;
            end
            if (word[8:1] !== want.data) begin
                $display("%0t: read_data expected %h actual %h", $time, want.data, word[8:1]);
                failures++;
            end
            if (word[16:9] !== want.col) begin
                $display("%0t: cursor_col expected %0d actual %0d", $time, want.col, word[16:9]);
                failures++;
            end
            if (word[22:17] !== want.row) begin
                $display("%0t: cursor_row expected %0d actual %0d", $time, want.row,
                         word[22:17]);
                failures++;
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    glyph_scoreboard sb;
    bit send_quiet;
    bit recv_quiet;

    text_glyph_framebuffer_renderer u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // quiet stretches give runs with no idling at all
    function int idle_draw(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 14));
    endfunction

    // valid stays high into the next item when there is no gap
    task automatic send_command(logic [2:0] cmd, logic [7:0] code, logic [7:0] px,
                                logic [7:0] py, logic [9:0] addr, bit drain = 1'b0);
        int gap;
        if ($urandom_range(0, 39) == 0) send_quiet = ~send_quiet;
        gap = idle_draw(send_quiet);
        @(negedge i_clk);
        if (gap != 0 || (drain && sb.pending() != 0)) begin
            s_tvalid <= 1'b0;
            while (drain && sb.pending() != 0) @(negedge i_clk);
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, addr, py, px, code, cmd};
        do @(posedge i_clk); while (!s_tready);
        sb.note_command(cmd, code, px, py, addr);
    endtask

    task automatic send_random(bit drain);
        logic [2:0] cmd;
        logic [7:0] code, px, py;
        logic [9:0] addr;
        int sel, page, x;
        code = 8'($urandom);
        px   = 8'($urandom);
        py   = 8'($urandom);
        addr = 10'($urandom);
        sel  = $urandom_range(0, 99);
        if (sel < 45) begin
            cmd = CMD_DRAW;
            case ($urandom_range(0, 3))
                0, 1:    code = sb.font_chars[$urandom_range(0, 43)];
                2:       code = 8'h61 + 8'($urandom_range(0, 25));
                default: code = 8'($urandom_range(0, 255));
            endcase
        end else if (sel < 70) begin
            cmd = CMD_READ;
            if ($urandom_range(0, 1) == 0) begin
                // look at what was just drawn, including the page below
                page = (int'(sb.row_now) / 8 + int'($urandom_range(0, 1))) % PAGE_COUNT;
                x = (int'(sb.col_now) + PANEL_WIDTH - int'($urandom_range(1, 12))) % PANEL_WIDTH;
                addr = 10'(page * PANEL_WIDTH + x);
            end
        end else if (sel < 80) begin
            cmd = CMD_SETPOS;
            if ($urandom_range(0, 4) != 0) begin
                px = 8'($urandom_range(0, PANEL_WIDTH - CELL_COLS));
                py = 8'($urandom_range(0, PANEL_HEIGHT - GLYPH_ROWS));
            end
        end else if (sel < 88) begin
            cmd = CMD_NEWLINE;
        end else if (sel < 89) begin
            cmd = CMD_CLEAR;
        end else if (sel < 92) begin
            cmd = 3'($urandom_range(5, 7));
        end else begin
            cmd  = CMD_DRAW;
            code = CHAR_NEWLINE;
        end
        send_command(cmd, code, px, py, addr, drain);
    endtask

    initial begin
        m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            int gap;
            if ($urandom_range(0, 39) == 0) recv_quiet = ~recv_quiet;
            gap = idle_draw(recv_quiet);
            @(negedge i_clk);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    initial begin
        sb = new();
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        send_command(CMD_READ, 8'h00, 8'h00, 8'h00, 10'd0);
        send_command(CMD_DRAW, "A", 8'hff, 8'hff, 10'h3ff);
        send_command(CMD_DRAW, "a", 8'h00, 8'h00, 10'd0);
        send_command(CMD_DRAW, 8'h00, 8'h00, 8'h00, 10'd0);     // NUL draws '?'
        send_command(CMD_DRAW, 8'hff, 8'h00, 8'h00, 10'd0);     // not in font
        send_command(CMD_DRAW, CHAR_NEWLINE, 8'h00, 8'h00, 10'd0);
        send_command(CMD_READ, 8'h00, 8'h00, 8'h00, 10'd0);
        send_command(CMD_READ, 8'h00, 8'h00, 8'h00, 10'd13);
        send_command(CMD_SETPOS, 8'h00, 8'd122, 8'd57, 10'd0);
        send_command(CMD_DRAW, "0", 8'h00, 8'h00, 10'd0);        // cursor ends at 128
        send_command(CMD_DRAW, "!", 8'h00, 8'h00, 10'd0);        // wraps back to the top
        send_command(CMD_READ, 8'h00, 8'h00, 8'h00, 10'd1019);
        send_command(CMD_SETPOS, 8'h00, 8'd123, 8'd0, 10'd0);
        send_command(CMD_SETPOS, 8'h00, 8'd0, 8'd58, 10'd0);
        send_command(CMD_SETPOS, 8'h00, 8'hff, 8'hff, 10'd0);
        send_command(CMD_SETPOS, 8'h00, 8'd0, 8'd55, 10'd0);
        send_command(CMD_NEWLINE, 8'h00, 8'h00, 8'h00, 10'd0);   // row 63, mostly clipped
        send_command(CMD_DRAW, "Z", 8'h00, 8'h00, 10'd0);
        send_command(CMD_READ, 8'h00, 8'h00, 8'h00, 10'd896);
        send_command(CMD_SETPOS, 8'h00, 8'd121, 8'd3, 10'd0);
        send_command(CMD_DRAW, "M", 8'h00, 8'h00, 10'd0);        // straddles two pages
        send_command(CMD_DRAW, "w", 8'h00, 8'h00, 10'd0);        // wraps to the next line
        send_command(CMD_READ, 8'h00, 8'h00, 8'h00, 10'd249);
        send_command(3'd5, 8'h00, 8'h00, 8'h00, 10'd0);
        send_command(3'd6, 8'h00, 8'h00, 8'h00, 10'd0);
        send_command(3'd7, 8'hff, 8'hff, 8'hff, 10'h3ff);
        send_command(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 10'd0);
        send_command(CMD_READ, 8'h00, 8'h00, 8'h00, 10'd121);

        for (int n = 0; n < 1750; n++)
            send_random(n == 875);

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (sb.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
